@@ src/breakpoint_search_with_fraction_unit_macros.svh @@
// assertion macros for the breakpoint search unit checker
// no dependencies; included by the checker file only
`ifndef BREAKPOINT_SEARCH_WITH_FRACTION_UNIT_MACROS_SVH
`define BREAKPOINT_SEARCH_WITH_FRACTION_UNIT_MACROS_SVH

// same-cycle implication
`define BSFU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSFU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bsfu_pkg.sv @@
// shared types and constants for the breakpoint search unit
// no dependencies
package bsfu_pkg;

   localparam int SLOT_WIDTH     = 8;
   localparam int VALUE_WIDTH    = 32;
   localparam int INDEX_WIDTH    = 8;
   localparam int FRACTION_WIDTH = 16;
   localparam int COUNT_WIDTH    = 9;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_SEARCH = 1'b1
   } mode_type;

   typedef enum logic {
      REG_ENTRY_COUNT = 1'b0,
      REG_KEYS_SIGNED = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      ALU_KEY_ENTRY,
      ALU_KEY_LEFT,
      ALU_RIGHT_LEFT,
      ALU_DIV_STEP
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_TEST,
      S_NUM,
      S_DEN,
      S_DIV
   } seq_state_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] entry_count;
      logic                   keys_signed;
   } cfg_type;

endpackage

@@ src/bsfu_ram.sv @@
// generic single-port-write, registered-read ram
// no dependencies
module bsfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bsfu_alu.sv @@
// shared subtractor: key compares, interval widths and divider steps
// depends on bsfu_pkg
module bsfu_alu #(
   parameter int KEY_WIDTH = 32
) (
   input  bsfu_pkg::alu_op_type   op,
   input  logic                   keys_signed,
   input  logic [KEY_WIDTH-1:0]   key,
   input  logic [KEY_WIDTH-1:0]   entry,
   input  logic [KEY_WIDTH-1:0]   left,
   input  logic [KEY_WIDTH-1:0]   right,
   input  logic [KEY_WIDTH-1:0]   rem,
   input  logic [KEY_WIDTH-1:0]   den,
   output logic [KEY_WIDTH+1:0]   diff,
   output logic                   neg,
   output logic                   zero
);
   import bsfu_pkg::*;

   localparam int DW = KEY_WIDTH + 2;

   logic [DW-1:0] key_o;
   logic [DW-1:0] entry_o;
   logic [DW-1:0] left_o;
   logic [DW-1:0] right_o;
   logic [DW-1:0] opa;
   logic [DW-1:0] opb;

   // order-preserving extension
   assign key_o   = keys_signed ? {{2{key[KEY_WIDTH-1]}}, key}     : {2'b00, key};
   assign entry_o = keys_signed ? {{2{entry[KEY_WIDTH-1]}}, entry} : {2'b00, entry};
   assign left_o  = keys_signed ? {{2{left[KEY_WIDTH-1]}}, left}   : {2'b00, left};
   assign right_o = keys_signed ? {{2{right[KEY_WIDTH-1]}}, right} : {2'b00, right};

   always_comb begin
      unique case (op)
         ALU_KEY_ENTRY: begin
            opa = key_o;
            opb = entry_o;
         end
         ALU_KEY_LEFT: begin
            opa = key_o;
            opb = left_o;
         end
         ALU_RIGHT_LEFT: begin
            opa = right_o;
            opb = left_o;
         end
         ALU_DIV_STEP: begin
            opa = {1'b0, rem, 1'b0};
            opb = {2'b00, den};
         end
      endcase
   end

   assign diff = opa - opb;
   assign neg  = diff[DW-1];
   assign zero = (diff == '0);

endmodule

@@ src/bsfu_csr.sv @@
// configuration registers on an apb-style port
// depends on bsfu_pkg
module bsfu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bsfu_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [bsfu_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [bsfu_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output bsfu_pkg::cfg_type                   cfg
);
   import bsfu_pkg::*;

   logic [COUNT_WIDTH-1:0] entry_count_ff;
   logic [COUNT_WIDTH-1:0] entry_count_in;
   logic                   keys_signed_ff;
   logic                   keys_signed_in;
   logic                   wr;
   csr_reg_type            reg_sel;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_WIDTH-1]);

   always_comb begin
      entry_count_in = entry_count_ff;
      keys_signed_in = keys_signed_ff;
      if (wr) begin
         unique case (reg_sel)
            REG_ENTRY_COUNT: entry_count_in = pwdata[COUNT_WIDTH-1:0];
            REG_KEYS_SIGNED: keys_signed_in = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ENTRY_COUNT: prdata = CSR_DATA_WIDTH'(entry_count_ff);
         REG_KEYS_SIGNED: prdata = CSR_DATA_WIDTH'(keys_signed_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= COUNT_WIDTH'(1);
         keys_signed_ff <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         keys_signed_ff <= keys_signed_in;
      end
   end

   assign cfg.entry_count = entry_count_ff;
   assign cfg.keys_signed = keys_signed_ff;

endmodule

@@ src/bsfu_seq.sv @@
// search and divide sequencer around the shared subtractor
// depends on bsfu_pkg and bsfu_alu
module bsfu_seq #(
   parameter int TABLE_DEPTH   = 256,
   parameter int KEY_WIDTH     = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [KEY_WIDTH-1:0]                key,
   input  bsfu_pkg::cfg_type                   cfg,
   output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
   input  logic [KEY_WIDTH-1:0]                rd_data,
   output logic                                rsp_strobe,
   output logic [bsfu_pkg::INDEX_WIDTH-1:0]    rsp_interval_index,
   output logic [bsfu_pkg::FRACTION_WIDTH-1:0] rsp_fraction
);
   import bsfu_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = (AW > COUNT_WIDTH) ? AW : COUNT_WIDTH;
   localparam int IW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;
   localparam int FW = (FRACTION_BITS > FRACTION_WIDTH) ? FRACTION_BITS : FRACTION_WIDTH;
   localparam int SW = $clog2(FRACTION_BITS);
   localparam int DW = KEY_WIDTH + 2;

   seq_state_type          state_ff, state_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [AW-1:0]          lo_ff, lo_in;
   logic [AW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          last_ff, last_in;
   logic [AW-1:0]          probe_ff;
   logic [KEY_WIDTH-1:0]   lo_val_ff, lo_val_in;
   logic [KEY_WIDTH-1:0]   hi_val_ff, hi_val_in;
   logic [KEY_WIDTH-1:0]   rem_ff, rem_in;
   logic [KEY_WIDTH-1:0]   den_ff, den_in;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [SW-1:0]          cnt_ff, cnt_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [AW-1:0]          rsp_index_ff, rsp_index_in;
   logic [FRACTION_BITS-1:0] rsp_frac_ff, rsp_frac_in;

   logic                   accept;
   logic                   finish;
   logic [AW-1:0]          fin_index;
   logic [FRACTION_BITS-1:0] fin_frac;
   logic [CW-1:0]          count_ext;
   logic [CW-1:0]          used_m1;
   logic [AW-1:0]          gap;
   logic                   gap_wide;
   logic [AW:0]            mid_sum;
   logic [AW-1:0]          mid_next;
   logic [IW-1:0]          index_ext;
   logic [FW-1:0]          frac_ext;

   alu_op_type             alu_op;
   logic [DW-1:0]          alu_diff;
   logic                   alu_neg;
   logic                   alu_zero;

   bsfu_alu #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_alu (
      .op          (alu_op),
      .keys_signed (cfg.keys_signed),
      .key         (key_ff),
      .entry       (rd_data),
      .left        (lo_val_ff),
      .right       (hi_val_ff),
      .rem         (rem_ff),
      .den         (den_ff),
      .diff        (alu_diff),
      .neg         (alu_neg),
      .zero        (alu_zero)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy && (req_mode == MODE_SEARCH);

   // saturate entry count to 1..TABLE_DEPTH, then minus one
   always_comb begin
      count_ext = CW'(cfg.entry_count);
      if (count_ext == '0) begin
         used_m1 = '0;
      end else if (32'(count_ext) > 32'(TABLE_DEPTH)) begin
         used_m1 = CW'(TABLE_DEPTH - 1);
      end else begin
         used_m1 = count_ext - CW'(1);
      end
   end

   assign gap      = hi_in - lo_in;
   assign gap_wide = (gap > AW'(1));
   assign mid_sum  = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_next = mid_sum[AW:1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_FIRST;
         S_FIRST: state_in = (alu_neg || alu_zero) ? S_IDLE : S_LAST;
         S_LAST: begin
            if (!alu_neg) begin
               state_in = S_IDLE;
            end else begin
               state_in = gap_wide ? S_TEST : S_NUM;
            end
         end
         S_TEST:  state_in = gap_wide ? S_TEST : S_NUM;
         S_NUM:   state_in = alu_zero ? S_IDLE : S_DEN;
         S_DEN:   state_in = S_DIV;
         S_DIV:   state_in = (cnt_ff == '0) ? S_IDLE : S_DIV;
         default: state_in = S_IDLE;
      endcase
   end

   // unit operation and table address
   always_comb begin
      alu_op  = ALU_KEY_ENTRY;
      rd_addr = '0;
      unique case (state_ff)
         S_IDLE:  rd_addr = '0;
         S_FIRST: rd_addr = last_ff;
         S_LAST:  rd_addr = mid_next;
         S_TEST:  rd_addr = mid_next;
         S_NUM:   alu_op  = ALU_KEY_LEFT;
         S_DEN:   alu_op  = ALU_RIGHT_LEFT;
         S_DIV:   alu_op  = ALU_DIV_STEP;
         default: rd_addr = '0;
      endcase
   end

   // datapath
   always_comb begin
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      last_in   = last_ff;
      lo_val_in = lo_val_ff;
      hi_val_in = hi_val_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      finish    = 1'b0;
      fin_index = lo_ff;
      fin_frac  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in  = key;
               last_in = used_m1[AW-1:0];
            end
         end
         S_FIRST: begin
            lo_val_in = rd_data;
            if (alu_neg || alu_zero) begin
               finish    = 1'b1;
               fin_index = '0;
            end
         end
         S_LAST: begin
            lo_in     = '0;
            hi_in     = last_ff;
            hi_val_in = rd_data;
            if (!alu_neg) begin
               finish    = 1'b1;
               fin_index = last_ff;
            end
         end
         S_TEST: begin
            if (alu_neg) begin
               hi_in     = probe_ff;
               hi_val_in = rd_data;
            end else begin
               lo_in     = probe_ff;
               lo_val_in = rd_data;
            end
         end
         S_NUM: begin
            rem_in = alu_diff[KEY_WIDTH-1:0];
            if (alu_zero) begin
               finish = 1'b1;
            end
         end
         S_DEN: begin
            den_in = alu_diff[KEY_WIDTH-1:0];
            cnt_in = SW'(FRACTION_BITS - 1);
            quo_in = '0;
         end
         S_DIV: begin
            if (!alu_neg) begin
               rem_in = alu_diff[KEY_WIDTH-1:0];
            end else begin
               rem_in = {rem_ff[KEY_WIDTH-2:0], 1'b0};
            end
            quo_in = {quo_ff[FRACTION_BITS-2:0], !alu_neg};
            cnt_in = cnt_ff - SW'(1);
            if (cnt_ff == '0) begin
               finish   = 1'b1;
               fin_frac = quo_in;
            end
         end
         default: finish = 1'b0;
      endcase
      rsp_strobe_in = finish;
      rsp_index_in  = finish ? fin_index : rsp_index_ff;
      rsp_frac_in   = finish ? fin_frac : rsp_frac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      last_ff      <= last_in;
      probe_ff     <= rd_addr;
      lo_val_ff    <= lo_val_in;
      hi_val_ff    <= hi_val_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_frac_ff  <= rsp_frac_in;
   end

   assign index_ext          = IW'(rsp_index_ff);
   assign frac_ext           = FW'(rsp_frac_ff);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_interval_index = index_ext[INDEX_WIDTH-1:0];
   assign rsp_fraction       = frac_ext[FRACTION_WIDTH-1:0];

endmodule

@@ src/breakpoint_search_with_fraction_unit.sv @@
// top level of the breakpoint search unit with interval fraction
// depends on bsfu_pkg, bsfu_csr, bsfu_ram and bsfu_seq
//
// a transaction is taken at a rising edge with start high and busy low.
// req_mode selects load (write req_entry_value at req_entry_slot) or search
// (locate req_key among the first entry_count breakpoints).
// a load gives no result and leaves busy low, so loads can follow each other
// in every cycle. a slot beyond the table depth is dropped.
// a search raises busy and ends with a one-cycle rsp_strobe carrying
// rsp_interval_index and rsp_fraction (unsigned, FRACTION_BITS fraction bits).
// a key at or below the first entry or at or above the last ends without a
// binary search; otherwise the search probes the table (at most
// ceil(log2(entry_count - 1)) probes) and then computes FRACTION_BITS quotient bits.
// an exact hit on a lower breakpoint ends with fraction 0, without dividing.
// the probes share one table read port, the divider one subtractor, one
// bit per cycle; busy drops as the strobe appears, so the next transaction
// may start in the strobe cycle. the receiver has no stall.
// reset idles the sequencer and sets entry_count to 1 and unsigned keys;
// table contents are undefined until written.
// registers: entry_count at byte 0, keys_signed at byte 4.
module breakpoint_search_with_fraction_unit #(
   parameter int TABLE_DEPTH   = 256,
   parameter int KEY_WIDTH     = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [bsfu_pkg::SLOT_WIDTH-1:0]     req_entry_slot,
   input  logic [bsfu_pkg::VALUE_WIDTH-1:0]    req_entry_value,
   input  logic [bsfu_pkg::VALUE_WIDTH-1:0]    req_key,
   output logic                                rsp_strobe,
   output logic [bsfu_pkg::INDEX_WIDTH-1:0]    rsp_interval_index,
   output logic [bsfu_pkg::FRACTION_WIDTH-1:0] rsp_fraction,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bsfu_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [bsfu_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [bsfu_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import bsfu_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SX = (AW > SLOT_WIDTH) ? AW : SLOT_WIDTH;

   cfg_type              cfg;
   logic                 wr_en;
   logic [SX-1:0]        slot_ext;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   assign slot_ext = SX'(req_entry_slot);
   assign wr_en    = start && !busy && (req_mode == MODE_LOAD)
                     && (32'(req_entry_slot) < 32'(TABLE_DEPTH));

   bsfu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bsfu_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (req_entry_value[KEY_WIDTH-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsfu_seq #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .KEY_WIDTH     (KEY_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .key                (req_key[KEY_WIDTH-1:0]),
      .cfg                (cfg),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_interval_index (rsp_interval_index),
      .rsp_fraction       (rsp_fraction)
   );

endmodule

@@ src/bsfu_checker.sv @@
// port-level assertions for the breakpoint search unit, bound to the top level
// depends on bsfu_pkg and the assertion macro header
`include "breakpoint_search_with_fraction_unit_macros.svh"

module bsfu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_mode,
   input logic rsp_strobe
);
   import bsfu_pkg::*;

   `BSFU_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "strobe held longer than one cycle")
   `BSFU_ASSERT_NXT(a_search_busy, clock, reset, start && !busy && (req_mode == MODE_SEARCH), busy, "search transaction did not raise busy")
   `BSFU_ASSERT_NXT(a_load_quiet, clock, reset, start && !busy && (req_mode == MODE_LOAD), !busy && !rsp_strobe, "load transaction raised busy or gave a result")
   `BSFU_ASSERT_IMP(a_strobe_end, clock, reset, rsp_strobe, !busy && $past(busy), "result not at the end of a search")

endmodule

bind breakpoint_search_with_fraction_unit bsfu_checker u_bsfu_checker (.*);

@@ verif/breakpoint_search_with_fraction_unit_test.sv @@
// self-checking testbench for breakpoint_search_with_fraction_unit: loads breakpoint tables,
// searches keys and checks interval index and fraction against a lookup kept in the bench
// depends on bsfu_pkg and the unit's sources
module breakpoint_search_with_fraction_unit_test;
   import bsfu_pkg::*;

   localparam int DEPTH = 256;

   typedef struct {
      logic [INDEX_WIDTH-1:0]    index;
      logic [FRACTION_WIDTH-1:0] fraction;
      logic [VALUE_WIDTH-1:0]    key;
   } lookup_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_mode;
   logic [SLOT_WIDTH-1:0]     req_entry_slot;
   logic [VALUE_WIDTH-1:0]    req_entry_value;
   logic [VALUE_WIDTH-1:0]    req_key;
   logic                      rsp_strobe;
   logic [INDEX_WIDTH-1:0]    rsp_interval_index;
   logic [FRACTION_WIDTH-1:0] rsp_fraction;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   logic [VALUE_WIDTH-1:0] breakpoints [DEPTH];
   cfg_type                shadow_cfg;
   lookup_type             pending_lookups [$];
   lookup_type             due;
   int                     mismatch_count = 0;
   int                     items_sent = 0;
   bit                     idling_on = 1'b1;

   breakpoint_search_with_fraction_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_entry_slot     (req_entry_slot),
      .req_entry_value    (req_entry_value),
      .req_key            (req_key),
      .rsp_strobe         (rsp_strobe),
      .rsp_interval_index (rsp_interval_index),
      .rsp_fraction       (rsp_fraction),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #2 clock = ~clock;

   function automatic longint as_ordered(input logic [VALUE_WIDTH-1:0] raw);
      if (shadow_cfg.keys_signed) return longint'($signed(raw));
      return longint'({32'b0, raw});
   endfunction

   function automatic int live_entries();
      if (shadow_cfg.entry_count == 0) return 1;
      if (shadow_cfg.entry_count > DEPTH) return DEPTH;
      return int'(shadow_cfg.entry_count);
   endfunction

   function automatic lookup_type locate_key(input logic [VALUE_WIDTH-1:0] key);
      lookup_type found;
      longint     k;
      longint     lower_val;
      longint     upper_val;
      longint     quotient;
      int         last;
      int         lo;
      int         hi;
      int         mid;
      last = live_entries() - 1;
      k = as_ordered(key);
      found.key = key;
      found.fraction = '0;
      lo = 0;
      if (k <= as_ordered(breakpoints[0])) begin
         lo = 0;
      end else if (k >= as_ordered(breakpoints[last])) begin
         lo = last;
      end else begin
         hi = last;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (k < as_ordered(breakpoints[mid])) hi = mid;
            else lo = mid;
         end
         lower_val = as_ordered(breakpoints[lo]);
         upper_val = as_ordered(breakpoints[hi]);
         if (k > lower_val && upper_val > lower_val) begin
            quotient = ((k - lower_val) <<< FRACTION_WIDTH) / (upper_val - lower_val);
            if (quotient > 65535) quotient = 65535;
            found.fraction = quotient[FRACTION_WIDTH-1:0];
         end
      end
      found.index = INDEX_WIDTH'(lo);
      return found;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] key,
                                input logic [31:0] expd, input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch, %s, key %h: expected %h, got %h", what, key, expd, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_lookups.size() == 0) begin
            flag_mismatch("result with no search pending", '0, '0,
                          {8'b0, rsp_interval_index, rsp_fraction});
         end else begin
            due = pending_lookups.pop_front();
            if (rsp_interval_index !== due.index)
               flag_mismatch("interval_index", due.key, 32'(due.index),
                             32'(rsp_interval_index));
            if (rsp_fraction !== due.fraction)
               flag_mismatch("fraction", due.key, 32'(due.fraction), 32'(rsp_fraction));
         end
      end
   end

   // one transaction; called at a rising edge; returns at the edge that took it or later
   task automatic issue(input mode_type mode, input logic [SLOT_WIDTH-1:0] slot,
                        input logic [VALUE_WIDTH-1:0] value, input logic [VALUE_WIDTH-1:0] key);
      start <= 1'b1;
      req_mode <= mode;
      req_entry_slot <= slot;
      req_entry_value <= value;
      req_key <= key;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      if (mode == MODE_LOAD) breakpoints[slot] = value;
      else pending_lookups.push_back(locate_key(key));
      if (idling_on && $urandom_range(99) < 11) begin
         start <= 1'b0;
         repeat ($urandom_range(3) == 0 ? $urandom_range(4, 40) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   task automatic load(input logic [SLOT_WIDTH-1:0] slot, input logic [VALUE_WIDTH-1:0] value);
      issue(MODE_LOAD, slot, value, $urandom);
   endtask

   task automatic search(input logic [VALUE_WIDTH-1:0] key);
      issue(MODE_SEARCH, SLOT_WIDTH'($urandom), $urandom, key);
   endtask

   task automatic wait_results();
      start <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type which, input logic [31:0] value);
      wait_results();
      repeat (4) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {which, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (which == REG_ENTRY_COUNT) shadow_cfg.entry_count = value[COUNT_WIDTH-1:0];
      else shadow_cfg.keys_signed = value[0];
   endtask

   // ascending in the current key order; tight steps give repeated entries
   task automatic fill_ascending(input int count);
      longint unsigned level;
      longint unsigned step;
      longint unsigned stride_max;
      logic [31:0]     flip;
      bit              tight;
      flip = shadow_cfg.keys_signed ? 32'h8000_0000 : 32'h0;
      tight = ($urandom_range(4) == 0);
      level = ($urandom_range(3) == 0) ? 0 : longint'($urandom >> $urandom_range(1, 31));
      stride_max = (64'hFFFF_FFFF - level) / count;
      for (int i = 0; i < count; i++) begin
         load(SLOT_WIDTH'(i), level[31:0] ^ flip);
         step = tight ? $urandom_range(3) : $urandom_range(32'(stride_max));
         if (level + step <= 64'hFFFF_FFFF) level += step;
      end
   endtask

   function automatic logic [31:0] pick_key(input int count);
      longint lower_val;
      longint upper_val;
      longint pick;
      int     i;
      i = $urandom_range(count - 1);
      lower_val = as_ordered(breakpoints[i]);
      upper_val = (i + 1 < count) ? as_ordered(breakpoints[i + 1]) : lower_val;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            pick = (upper_val > lower_val) ?
                   lower_val + longint'($urandom) % (upper_val - lower_val) : lower_val;
         end
         4, 5: pick = lower_val;
         6: pick = $urandom_range(1) ? lower_val + 1 : lower_val - 1;
         7: begin
            case ($urandom_range(3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         default: return $urandom;
      endcase
      return pick[31:0];
   endfunction

   task automatic test_reset_state();
      for (int i = 0; i < DEPTH; i++)
         load(SLOT_WIDTH'(i), (i == DEPTH - 1) ? 32'hFFFF_FFFF : {8'(i), 24'(i)});
      search(32'h0000_0000);
      search(32'h1234_5678);
      search(32'hFFFF_FFFF);
   endtask

   task automatic test_unsigned_extremes();
      write_register(REG_KEYS_SIGNED, 32'h0);
      write_register(REG_ENTRY_COUNT, 32'd256);
      search(32'h0000_0000);
      search(32'hFFFF_FFFF);
      search(32'h0300_0003);
      search(32'h0380_0003);
      search(32'h0300_0004);
      search(32'hFFFF_FFFE);
      search(32'h8000_0000);
      write_register(REG_ENTRY_COUNT, 32'd0);
      search(32'h5000_0000);
      write_register(REG_ENTRY_COUNT, 32'd511);
      search(32'hFFFF_FFFE);
      write_register(REG_ENTRY_COUNT, 32'd2);
      search(32'h0080_0000);
   endtask

   task automatic test_signed_keys();
      write_register(REG_KEYS_SIGNED, 32'h1);
      write_register(REG_ENTRY_COUNT, 32'd4);
      load(8'd0, 32'h8000_0000);
      load(8'd1, 32'hFFFF_FFF0);
      load(8'd2, 32'h0000_0010);
      load(8'd3, 32'h7FFF_FFFF);
      search(32'h8000_0000);
      search(32'h7FFF_FFFF);
      search(32'hFFFF_FFF8);
      search(32'h0000_0000);
      search(32'h4000_0000);
   endtask

   task automatic test_unsorted_table();
      write_register(REG_KEYS_SIGNED, 32'h0);
      load(8'd1, 32'h7FFF_FFF0);
      search(32'h4000_0000);
      search(32'h9000_0000);
   endtask

   task automatic test_random_lookups();
      int unsigned extremes [7] = '{0, 1, 2, 255, 256, 257, 511};
      int          first;
      int          live;
      int          shape;
      logic [31:0] count_value;
      first = items_sent;
      while (items_sent - first < 1500) begin
         idling_on = ($urandom_range(5) != 0);
         shape = $urandom_range(9);
         count_value = (shape < 2) ? extremes[$urandom_range(6)] :
                       $urandom_range(2, (shape < 4) ? 256 : 24);
         write_register(REG_ENTRY_COUNT, ($urandom & ~32'h1FF) | count_value);
         write_register(REG_KEYS_SIGNED, $urandom);
         live = live_entries();
         if (shape == 9) begin
            for (int i = 0; i < live; i++) load(SLOT_WIDTH'(i), $urandom);
         end else begin
            fill_ascending(live);
         end
         repeat ($urandom_range(40, 120)) begin
            // stray table write, may leave the table out of order
            if ($urandom_range(19) == 0) load(SLOT_WIDTH'($urandom), $urandom);
            else search(pick_key(live));
            if ($urandom_range(199) == 0) wait_results();
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_LOAD;
      req_entry_slot <= '0;
      req_entry_value <= '0;
      req_key <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      shadow_cfg.entry_count = COUNT_WIDTH'(1);
      shadow_cfg.keys_signed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_unsigned_extremes();
      test_signed_keys();
      test_unsorted_table();
      test_random_lookups();
      wait_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0) begin
         $display("breakpoint_search_with_fraction_unit_test passed");
      end else begin
         $display("breakpoint_search_with_fraction_unit_test failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("breakpoint_search_with_fraction_unit_test failed");
      $finish;
   end

endmodule
